### src/ntuple_value_eval_and_td_update_macros.svh
// assertion macros used by the checker file of the n-tuple evaluator
// depends on: a clk and an active-high rst in the scope that uses them
`ifndef NTUPLE_VALUE_EVAL_AND_TD_UPDATE_MACROS_SVH
`define NTUPLE_VALUE_EVAL_AND_TD_UPDATE_MACROS_SVH

// condition implies consequence in the same cycle
`define NVE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence starting in the next cycle
`define NVE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/nvetd_pkg.sv
// shared constants and the tuple cell table of the n-tuple evaluator
// depends on: nothing
package nvetd_pkg;

  // network shape
  localparam int NUM_TUPLES      = 17;
  localparam int CELLS_PER_TUPLE = 4;
  localparam int CELL_BITS       = 4;

  // defaults of the top level parameters
  localparam int TILE_BITS_DEF   = 4;
  localparam int WEIGHT_BITS_DEF = 32;

  // field widths
  localparam int BOARD_BITS   = 64;
  localparam int TARGET_BITS  = 32;
  localparam int VALUE_BITS   = 32;
  localparam int LR_BITS      = 16;
  localparam int FRAC_BITS    = 16;
  localparam int ERR_BITS     = 48;
  localparam int S_TDATA_BITS = BOARD_BITS + TARGET_BITS;
  localparam int S_TUSER_BITS = 1;
  localparam int M_TDATA_BITS = VALUE_BITS;

  localparam logic [LR_BITS-1:0] LR_RESET = 16'd164;

  // request kinds carried in tuser
  localparam logic REQ_EVAL   = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  // board cells feeding each tuple, first cell most significant in the index
  localparam logic [CELL_BITS-1:0] TUPLE_CELLS [NUM_TUPLES][CELLS_PER_TUPLE] = '{
    '{4'd0,  4'd1,  4'd2,  4'd3 },
    '{4'd4,  4'd5,  4'd6,  4'd7 },
    '{4'd8,  4'd9,  4'd10, 4'd11},
    '{4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd0,  4'd4,  4'd8,  4'd12},
    '{4'd1,  4'd5,  4'd9,  4'd13},
    '{4'd2,  4'd6,  4'd10, 4'd14},
    '{4'd3,  4'd7,  4'd11, 4'd15},
    '{4'd0,  4'd1,  4'd5,  4'd4 },
    '{4'd1,  4'd2,  4'd6,  4'd5 },
    '{4'd2,  4'd3,  4'd7,  4'd6 },
    '{4'd4,  4'd5,  4'd9,  4'd8 },
    '{4'd5,  4'd6,  4'd10, 4'd9 },
    '{4'd6,  4'd7,  4'd11, 4'd10},
    '{4'd8,  4'd9,  4'd13, 4'd12},
    '{4'd9,  4'd10, 4'd14, 4'd13},
    '{4'd10, 4'd11, 4'd15, 4'd14}
  };

endpackage

### src/ntuple_value_eval_and_td_update.sv
// n-tuple network evaluator with temporal-difference weight update
// depends on: nvetd_pkg
//
//  channel | direction | handshake            | word
//  s       | in        | s_tvalid / s_tready  | s_tuser req_type, s_tdata board, target
//  m       | out       | m_tvalid / m_tready  | m_tdata value
//  cfg     | in        | cfg_valid / cfg_ready| cfg_data step_size
//
// evaluate: bank read, two adder levels and output register, then back to idle for the next accept
// update: as evaluate, then multiply, rounding and bank write-back
// the 17 weight banks are read once per word and written once per update word, so words never overlap
// after reset a clearing pass over all 2^(4*TILE_BITS) entries (65536 by default)
// zeroes all banks with s_tready low; cfg writes are taken at all times
// a result waiting in the output register holds the block in its output cycle
module ntuple_value_eval_and_td_update #(
  parameter int TILE_BITS   = nvetd_pkg::TILE_BITS_DEF,
  parameter int WEIGHT_BITS = nvetd_pkg::WEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [nvetd_pkg::S_TDATA_BITS-1:0] s_tdata,   // board [63:0], target [95:64]
  input  logic [nvetd_pkg::S_TUSER_BITS-1:0] s_tuser,   // req_type [0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [nvetd_pkg::M_TDATA_BITS-1:0] m_tdata,   // value [31:0]
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nvetd_pkg::LR_BITS-1:0]     cfg_data   // step_size [15:0]
);

  localparam int NT       = nvetd_pkg::NUM_TUPLES;
  localparam int CPT      = nvetd_pkg::CELLS_PER_TUPLE;
  localparam int CB       = nvetd_pkg::CELL_BITS;
  localparam int EB       = nvetd_pkg::ERR_BITS;
  localparam int VB       = nvetd_pkg::VALUE_BITS;
  localparam int TB       = nvetd_pkg::TARGET_BITS;
  localparam int IDX_W    = CPT * TILE_BITS;
  localparam int DEPTH    = 1 << IDX_W;
  localparam int CELL_EXT = TILE_BITS + CB;
  localparam int SUM_W    = WEIGHT_BITS + $clog2(NT);
  localparam int NPART    = (NT + CPT - 1) / CPT;
  localparam int OUT_W    = (SUM_W > VB + 1) ? SUM_W : VB + 1;
  localparam int DIFF_W   = ((SUM_W > TB) ? SUM_W : TB) + 1;
  localparam int CMP_W    = (DIFF_W > EB) ? DIFF_W : EB + 1;
  localparam int NW       = ((WEIGHT_BITS > EB + 1) ? WEIGHT_BITS : EB + 1) + 1;
  localparam int PROD_W   = EB + nvetd_pkg::LR_BITS;
  localparam int FB       = nvetd_pkg::FRAC_BITS;

  localparam logic [EB-1:0] ERR_HI = {1'b0, {(EB-1){1'b1}}};
  localparam logic [EB-1:0] ERR_LO = {1'b1, {(EB-1){1'b0}}};
  localparam logic signed [CMP_W-1:0] ERR_MAX_C = CMP_W'($signed(ERR_HI));
  localparam logic signed [CMP_W-1:0] ERR_MIN_C = CMP_W'($signed(ERR_LO));
  localparam logic [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
  localparam logic [VB-1:0] V_MAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic [VB-1:0] V_MIN = {1'b1, {(VB-1){1'b0}}};
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FB - 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SUM1  = 8'b0000_0100,
    S_SUM2  = 8'b0000_1000,
    S_ERR   = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_DELTA = 8'b0100_0000,
    S_WB    = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic [IDX_W-1:0] clr_cnt;
  logic [nvetd_pkg::LR_BITS-1:0] step_size;

  logic rd_en, out_free;
  logic [IDX_W-1:0] idx_c [NT];
  logic [IDX_W-1:0] idx_r [NT];
  logic [WEIGHT_BITS-1:0] rdata [NT];
  logic [IDX_W-1:0] wr_addr [NT];
  logic [WEIGHT_BITS-1:0] wr_data [NT];
  logic [WEIGHT_BITS-1:0] new_w [NT];
  logic wr_en;

  logic req_r;
  logic signed [TB-1:0] target_r;
  logic signed [SUM_W-1:0] part_c [NPART];
  logic signed [SUM_W-1:0] part_r [NPART];
  logic signed [SUM_W-1:0] sum_c, sum_r;
  logic signed [CMP_W-1:0] diff_c;
  logic [EB-1:0] err_c, mag_c, mag_r;
  logic neg_c, neg_r;
  logic signed [OUT_W-1:0] sum_x;
  logic [VB-1:0] value_c;
  logic [PROD_W-1:0] prod_r, rnd_c;
  logic [EB-1:0] rmag_c;
  logic signed [EB:0] delta_c, delta_r;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign rd_en     = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // table index of every tuple from the incoming board
  always_comb begin
    logic [CB-1:0] nib;
    logic [CELL_EXT-1:0] nib_x;
    for (int t = 0; t < NT; t++) begin
      idx_c[t] = '0;
      for (int k = 0; k < CPT; k++) begin
        nib   = s_tdata[CB*nvetd_pkg::TUPLE_CELLS[t][k] +: CB];
        nib_x = CELL_EXT'(nib);
        idx_c[t][(CPT-1-k)*TILE_BITS +: TILE_BITS] = nib_x[TILE_BITS-1:0];
      end
    end
  end

  // weight banks: one read on accept, one write per clear step or write-back
  // the write-back ends before the sequencer returns to idle, so no forwarding is needed
  assign wr_en = (state == S_CLEAR) || (state == S_WB);
  always_comb begin
    for (int t = 0; t < NT; t++) begin
      wr_addr[t] = (state == S_CLEAR) ? clr_cnt : idx_r[t];
      wr_data[t] = (state == S_CLEAR) ? '0 : new_w[t];
    end
  end

  for (genvar g = 0; g < NT; g++) begin : g_bank
    logic [WEIGHT_BITS-1:0] bank_mem [DEPTH];
    always_ff @(posedge clk) begin
      if (wr_en) bank_mem[wr_addr[g]] <= wr_data[g];
      if (rd_en) rdata[g] <= bank_mem[idx_c[g]];
    end
  end

  // first adder level: groups of up to four weights
  always_comb begin
    int ti;
    for (int j = 0; j < NPART; j++) begin
      part_c[j] = '0;
      for (int k = 0; k < CPT; k++) begin
        ti = (j * CPT + k < NT) ? j * CPT + k : 0;
        if (j * CPT + k < NT) part_c[j] = part_c[j] + SUM_W'($signed(rdata[ti]));
      end
    end
  end

  // second adder level
  always_comb begin
    sum_c = '0;
    for (int j = 0; j < NPART; j++) sum_c = sum_c + part_r[j];
  end

  // saturated output value and clamped error magnitude
  always_comb begin
    sum_x = OUT_W'(sum_r);
    if ((&sum_x[OUT_W-1:VB-1]) || !(|sum_x[OUT_W-1:VB-1])) value_c = sum_x[VB-1:0];
    else value_c = sum_x[OUT_W-1] ? V_MIN : V_MAX;

    diff_c = CMP_W'(target_r) - CMP_W'(sum_r);
    if (diff_c > ERR_MAX_C) err_c = ERR_HI;
    else if (diff_c < ERR_MIN_C) err_c = ERR_LO;
    else err_c = diff_c[EB-1:0];
    neg_c = err_c[EB-1];
    mag_c = neg_c ? (~err_c) + EB'(1) : err_c;
  end

  // round the Q.16 product to an integer, ties away from zero, and restore the sign
  always_comb begin
    rnd_c   = prod_r + ROUND_HALF;
    rmag_c  = rnd_c[PROD_W-1:FB];
    delta_c = neg_r ? -$signed({1'b0, rmag_c}) : $signed({1'b0, rmag_c});
  end

  // saturating weight update for every bank
  always_comb begin
    logic signed [NW-1:0] wide;
    for (int t = 0; t < NT; t++) begin
      wide = NW'($signed(rdata[t])) + NW'(delta_r);
      if ((&wide[NW-1:WEIGHT_BITS-1]) || !(|wide[NW-1:WEIGHT_BITS-1]))
        new_w[t] = wide[WEIGHT_BITS-1:0];
      else
        new_w[t] = wide[NW-1] ? W_MIN : W_MAX;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (&clr_cnt) state_next = S_IDLE;
      S_IDLE:  if (s_tvalid) state_next = S_SUM1;
      S_SUM1:  state_next = S_SUM2;
      S_SUM2:  state_next = S_ERR;
      S_ERR: begin
        if (out_free) state_next = (req_r == nvetd_pkg::REQ_UPDATE) ? S_MUL : S_IDLE;
      end
      S_MUL:   state_next = S_DELTA;
      S_DELTA: state_next = S_WB;
      S_WB:    state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      m_tvalid  <= 1'b0;
      step_size <= nvetd_pkg::LR_RESET;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + IDX_W'(1);
      if (cfg_valid && cfg_ready) step_size <= cfg_data;
      if (state == S_ERR && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      idx_r    <= idx_c;
      req_r    <= s_tuser[0];
      target_r <= $signed(s_tdata[nvetd_pkg::BOARD_BITS +: TB]);
    end
    if (state == S_SUM1) part_r <= part_c;
    if (state == S_SUM2) sum_r <= sum_c;
    if (state == S_ERR) begin
      neg_r <= neg_c;
      mag_r <= mag_c;
      if (out_free) m_tdata <= value_c;
    end
    if (state == S_MUL) prod_r <= PROD_W'(mag_r) * PROD_W'(step_size);
    if (state == S_DELTA) delta_r <= delta_c;
  end

endmodule

### src/nvetd_checker.sv
// port-level assertions for the n-tuple evaluator, bound to its top level
// depends on: nvetd_pkg, ntuple_value_eval_and_td_update_macros.svh
`include "ntuple_value_eval_and_td_update_macros.svh"

module nvetd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [nvetd_pkg::M_TDATA_BITS-1:0] m_tdata
);

  // one word in flight: after an accept, s_tready stays low while the word is summed and output
  `NVE_ASSERT_NEXT(a_one_word_in_flight, s_tvalid && s_tready, !s_tready ##1 !s_tready ##1 !s_tready, "input accepted while a word is still in progress")

  // a new result only comes after the read and both adder levels
  `NVE_ASSERT_NOW(a_result_after_sum, $rose(m_tvalid), $past(!s_tready) && $past(!s_tready, 2) && $past(!s_tready, 3), "result appeared without a full evaluation")

  // a stalled result stays put
  `NVE_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result dropped or changed")

endmodule

bind ntuple_value_eval_and_td_update nvetd_checker u_nvetd_checker (.*);

### test/ntuple_value_eval_and_td_update_tb.sv
// self-checking bench for the n-tuple evaluator with td weight update
// depends on: nvetd_pkg, ntuple_value_eval_and_td_update
`timescale 1ns / 1ps

module ntuple_value_eval_and_td_update_tb;

  localparam int     NT          = nvetd_pkg::NUM_TUPLES;
  localparam int     CB          = nvetd_pkg::CELL_BITS;
  localparam int     ADDR_BITS   = nvetd_pkg::CELLS_PER_TUPLE * nvetd_pkg::TILE_BITS_DEF;
  localparam int     CYCLE_LIMIT = 600000;
  localparam int     SETTLE      = 12;
  localparam int     RAND_ITEMS  = 255;
  localparam longint VAL_MAX     = 64'sd2147483647;
  localparam longint VAL_MIN     = -64'sd2147483648;
  localparam longint ERR_MAX     = (64'sd1 <<< 47) - 64'sd1;
  localparam longint ERR_MIN     = -(64'sd1 <<< 47);

  typedef struct {
    logic                              req;
    logic [nvetd_pkg::BOARD_BITS-1:0]  board;
    logic [nvetd_pkg::TARGET_BITS-1:0] target;
  } board_req_t;

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               s_tvalid  = 1'b0;
  logic                               s_tready;
  logic [nvetd_pkg::S_TDATA_BITS-1:0] s_tdata   = '0;  // board [63:0], target [95:64]
  logic [nvetd_pkg::S_TUSER_BITS-1:0] s_tuser   = '0;  // req_type [0]
  logic                               m_tvalid;
  logic                               m_tready  = 1'b0;
  logic [nvetd_pkg::M_TDATA_BITS-1:0] m_tdata;         // value [31:0]
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [nvetd_pkg::LR_BITS-1:0]      cfg_data  = '0;  // step_size [15:0]

  // shadow copy of the network
  int                            net_weights [NT][1 << ADDR_BITS];
  logic [nvetd_pkg::LR_BITS-1:0] step_rate = nvetd_pkg::LR_RESET;

  board_req_t                       pending_reqs [$];
  logic [nvetd_pkg::VALUE_BITS-1:0] expected_values [$];
  board_req_t                       in_flight;
  logic [nvetd_pkg::BOARD_BITS-1:0] board_pool [8];

  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  int src_wait     = 0;
  int sink_wait    = 0;
  int sink_stall   = 0;
  int n_results    = 0;
  int n_errors     = 0;
  int cycle_count  = 0;

  ntuple_value_eval_and_td_update i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // table address of one tuple, first cell most significant
  function automatic logic [ADDR_BITS-1:0] tuple_addr(
    logic [nvetd_pkg::BOARD_BITS-1:0] b, int t);
    logic [ADDR_BITS-1:0] a;
    a = '0;
    for (int k = 0; k < nvetd_pkg::CELLS_PER_TUPLE; k++)
      a = {a[ADDR_BITS-CB-1:0], b[CB*nvetd_pkg::TUPLE_CELLS[t][k] +: CB]};
    return a;
  endfunction

  // value of a board before update, then the td step on the shadow weights
  function automatic logic [nvetd_pkg::VALUE_BITS-1:0] score_board(board_req_t r);
    logic [ADDR_BITS-1:0]             addr [NT];
    logic [nvetd_pkg::VALUE_BITS-1:0] val;
    longint                           sum, err, delta, w;
    longint unsigned                  mag, prod, rmag;
    sum = 0;
    for (int t = 0; t < NT; t++) begin
      addr[t] = tuple_addr(r.board, t);
      sum += longint'(net_weights[t][addr[t]]);
    end
    if (sum > VAL_MAX) val = VAL_MAX[nvetd_pkg::VALUE_BITS-1:0];
    else if (sum < VAL_MIN) val = VAL_MIN[nvetd_pkg::VALUE_BITS-1:0];
    else val = sum[nvetd_pkg::VALUE_BITS-1:0];
    if (r.req == nvetd_pkg::REQ_UPDATE) begin
      // error from the unsaturated sum, rounded to nearest, ties away from zero
      err = longint'($signed(r.target)) - sum;
      if (err > ERR_MAX) err = ERR_MAX;
      if (err < ERR_MIN) err = ERR_MIN;
      mag   = (err < 0) ? longint'(-err) : longint'(err);
      prod  = mag * {48'd0, step_rate};
      rmag  = (prod + 64'd32768) >> nvetd_pkg::FRAC_BITS;
      delta = (err < 0) ? -longint'(rmag) : longint'(rmag);
      for (int t = 0; t < NT; t++) begin
        w = longint'(net_weights[t][addr[t]]) + delta;
        if (w > VAL_MAX) w = VAL_MAX;
        if (w < VAL_MIN) w = VAL_MIN;
        net_weights[t][addr[t]] = int'(w);
      end
    end
    return val;
  endfunction

  function automatic int idle_gap(bit on);
    return on ? int'($urandom_range(0, 15)) : 0;
  endfunction

  // boards with few tile values so tuples share table entries
  function automatic logic [nvetd_pkg::BOARD_BITS-1:0] sparse_board();
    logic [nvetd_pkg::BOARD_BITS-1:0] b;
    b = '0;
    for (int c = 0; c < 16; c++)
      b[CB*c +: CB] = ($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom_range(0, 2));
    return b;
  endfunction

  function automatic board_req_t random_req();
    board_req_t r;
    int         sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) r.board = board_pool[$urandom_range(0, 7)];
    else if (sel < 7) r.board = sparse_board();
    else r.board = {$urandom, $urandom};
    r.req = ($urandom_range(0, 3) != 0) ? nvetd_pkg::REQ_UPDATE : nvetd_pkg::REQ_EVAL;
    sel = $urandom_range(0, 7);
    case (sel)
      0:       r.target = 32'h7FFF_FFFF;
      1:       r.target = 32'h8000_0000;
      2, 3, 4: r.target = 32'($signed($urandom_range(0, 2097151)) - 1048576);
      default: r.target = $urandom;
    endcase
    return r;
  endfunction

  task automatic send(logic req, logic [nvetd_pkg::BOARD_BITS-1:0] b,
                      logic [nvetd_pkg::TARGET_BITS-1:0] tgt);
    board_req_t r;
    r.req    = req;
    r.board  = b;
    r.target = tgt;
    pending_reqs.push_back(r);
  endtask

  // wait until every word is through and the block has settled
  // checked between edges so the driver and monitor updates have landed
  task automatic drain();
    @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_values.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_rate(logic [nvetd_pkg::LR_BITS-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    step_rate = v;
    cfg_valid <= 1'b0;
  endtask

  // input driver, fed from pending_reqs
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_values.push_back(score_board(in_flight));
        src_wait = idle_gap(src_idle_on);
      end
      if (s_tvalid && !s_tready) begin
        // hold the word
      end else if (src_wait > 0) begin
        src_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_flight = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {in_flight.target, in_flight.board};
        s_tuser  <= in_flight.req;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and output back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_values.size() == 0) begin
          $display("%0t: unexpected word, got %h", $time, m_tdata);
          n_errors++;
        end else if (expected_values[0] !== m_tdata) begin
          $display("%0t: value mismatch, expected %h, got %h",
                   $time, expected_values[0], m_tdata);
          n_errors++;
          void'(expected_values.pop_front());
        end else begin
          void'(expected_values.pop_front());
        end
        n_results++;
        // long hold-off so the block fills and stalls its input
        if (n_results == 300 || n_results == 1100) sink_stall = 500;
        else sink_wait = idle_gap(sink_idle_on);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    logic [nvetd_pkg::LR_BITS-1:0] rates [6];
    rates = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom), 16'h8000, 16'($urandom)};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset rate: empty network, extreme boards and targets
    send(nvetd_pkg::REQ_EVAL,   64'h0, 32'h0);
    send(nvetd_pkg::REQ_EVAL,   64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send(nvetd_pkg::REQ_UPDATE, 64'h0, 32'h7FFF_FFFF);
    send(nvetd_pkg::REQ_EVAL,   64'h0, 32'h0);
    send(nvetd_pkg::REQ_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
    send(nvetd_pkg::REQ_EVAL,   64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send(nvetd_pkg::REQ_UPDATE, 64'h0123_4567_89AB_CDEF, 32'h0000_0001);
    drain();

    // half step: rounding ties in both directions
    write_rate(16'h8000);
    send(nvetd_pkg::REQ_UPDATE, 64'h1111_2222_3333_4444, 32'h0000_0001);
    send(nvetd_pkg::REQ_EVAL,   64'h1111_2222_3333_4444, 32'h0);
    send(nvetd_pkg::REQ_UPDATE, 64'h5555_6666_7777_8888, 32'hFFFF_FFFF);
    send(nvetd_pkg::REQ_EVAL,   64'h5555_6666_7777_8888, 32'h0);
    drain();

    // full step: weights and value saturate both ways
    write_rate(16'hFFFF);
    repeat (3) send(nvetd_pkg::REQ_UPDATE, 64'hFEDC_BA98_7654_3210, 32'h7FFF_FFFF);
    send(nvetd_pkg::REQ_EVAL, 64'hFEDC_BA98_7654_3210, 32'h0);
    repeat (3) send(nvetd_pkg::REQ_UPDATE, 64'hFEDC_BA98_7654_3210, 32'h8000_0000);
    send(nvetd_pkg::REQ_EVAL, 64'hFEDC_BA98_7654_3210, 32'h0);
    send(nvetd_pkg::REQ_UPDATE, 64'hFEDC_BA98_7654_3210, 32'h0);
    send(nvetd_pkg::REQ_EVAL, 64'hFEDC_BA98_7654_3210, 32'h0);
    drain();

    // random phases, one rate each, idling switched per phase
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 8; i++) board_pool[i] = sparse_board();
      src_idle_on  = (ph % 3 != 1);
      sink_idle_on = (ph % 3 != 2);
      write_rate(rates[ph]);
      for (int i = 0; i < RAND_ITEMS; i++) pending_reqs.push_back(random_req());
      drain();
    end

    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/nvetd_pkg.sv
src/ntuple_value_eval_and_td_update.sv
src/nvetd_checker.sv
test/ntuple_value_eval_and_td_update_tb.sv
